/* design/bar_led_matrix_scanner_macros.svh */
// Assertion macros for the LED matrix scanner.
`ifndef BAR_LED_MATRIX_SCANNER_MACROS_SVH
`define BAR_LED_MATRIX_SCANNER_MACROS_SVH
`ifndef SYNTH
`define BLS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bls: same-cycle check failed");
`define BLS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bls: next-cycle check failed");
`else
`define BLS_ASSERT_SAME(label, ante, cons)
`define BLS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* design/bls_pkg.sv */
// Shared types and constants for the LED matrix scanner.
`timescale 1ns / 1ps

package bls_pkg;

    localparam int RowCount  = 18;
    localparam int RowW      = 5;
    localparam int PeriodW   = 16;
    localparam int SinkW     = 16;

    localparam logic [RowW-1:0]  LastRow   = 5'd17;
    localparam logic [RowW-1:0]  BlankRow  = 5'd18;
    localparam logic [SinkW-1:0] BlankSink = 16'h00FF;

    localparam logic [1:0] ReqTick  = 2'd0;
    localparam logic [1:0] ReqBar   = 2'd1;
    localparam logic [1:0] ReqPixel = 2'd2;
    localparam logic [1:0] ReqClear = 2'd3;

    typedef logic [7:0] row_byte_t;

    typedef struct packed {
        logic [1:0]      req_type;
        logic [RowW-1:0] row_index;
        logic [3:0]      bar_height;
        logic [2:0]      pixel_column;
    } req_t;

    typedef struct packed {
        row_byte_t        source_byte;
        logic [SinkW-1:0] sink_word;
        logic             select_first;
        logic             select_last;
    } scan_t;

    // thermometer code, saturating at eight lit LEDs
    function automatic row_byte_t bar_code(input logic [3:0] height);
        logic [8:0] ones;
        begin
            ones = (9'd1 << height[2:0]) - 9'd1;
            bar_code = height[3] ? 8'hFF : ones[7:0];
        end
    endfunction

endpackage

/* design/bls_req_if.sv */
// Request channel: valid/ready with one request beat.
`timescale 1ns / 1ps

interface bls_req_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                req_type;
    logic [bls_pkg::RowW-1:0]  row_index;
    logic [3:0]                bar_height;
    logic [2:0]                pixel_column;

    modport source (output valid, req_type, row_index, bar_height, pixel_column,
                    input ready);
    modport sink   (input valid, req_type, row_index, bar_height, pixel_column,
                    output ready);
endinterface

/* design/bls_scan_if.sv */
// Scan step channel: valid/ready with one drive pattern per beat.
`timescale 1ns / 1ps

interface bls_scan_if;
    logic                       valid;
    logic                       ready;
    logic [7:0]                 source_byte;
    logic [bls_pkg::SinkW-1:0]  sink_word;
    logic                       select_first;
    logic                       select_last;

    modport source (output valid, source_byte, sink_word, select_first, select_last,
                    input ready);
    modport sink   (input valid, source_byte, sink_word, select_first, select_last,
                    output ready);
endinterface

/* design/bar_led_matrix_scanner.sv */
// Top level: 18-row frame store, tick prescaler and row scan sequencer.
// Requests are registered on entry and processed from that register, so one
// request beat is taken every clock; a request that emits a scan step needs the
// output register to be free or draining, otherwise the request register holds.
// Requests pass the request and then the output register. Tick requests advance
// a 16-bit prescaler; when it reaches scan_period a step fires for the current
// row, a blanking step after row 17. cfg_wr_en / cfg_wr_data write scan_period.
`timescale 1ns / 1ps
`include "bar_led_matrix_scanner_macros.svh"

module bar_led_matrix_scanner (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [bls_pkg::PeriodW-1:0]   cfg_wr_data,
    bls_req_if.sink                       req,
    bls_scan_if.source                    scan
);

    logic [bls_pkg::PeriodW-1:0] scan_period_reg;
    logic [bls_pkg::PeriodW-1:0] tick_count_reg, tick_count_next;
    logic [bls_pkg::RowW-1:0]    scan_row_reg, scan_row_next;
    bls_pkg::row_byte_t          frame_rows_reg  [bls_pkg::RowCount];
    bls_pkg::row_byte_t          frame_rows_next [bls_pkg::RowCount];

    logic                        in_valid_reg;
    bls_pkg::req_t               in_item_reg;
    logic                        out_valid_reg;
    bls_pkg::scan_t              out_item_reg, out_item_next;

    logic [bls_pkg::PeriodW-1:0] tick_inc;
    logic                        step_fire;
    logic                        out_free;
    logic                        stage_fire;
    logic                        res_load;
    logic                        in_take;
    logic [bls_pkg::RowW-1:0]    bar_row;
    logic [bls_pkg::RowW-1:0]    sink_shift;

    assign tick_inc  = tick_count_reg + 16'd1;
    assign step_fire = (in_item_reg.req_type == bls_pkg::ReqTick)
                       && (tick_inc >= scan_period_reg);
    assign out_free  = !out_valid_reg || scan.ready;
    // a request with no scan beat never waits on the output side
    assign stage_fire = in_valid_reg && (out_free || !step_fire);
    assign res_load   = stage_fire && step_fire;
    assign req.ready  = !in_valid_reg || stage_fire;
    assign in_take    = req.valid && req.ready;

    assign bar_row    = bls_pkg::LastRow - in_item_reg.row_index;
    assign sink_shift = scan_row_reg - 5'd1;

    always_comb
    begin
        tick_count_next = tick_count_reg;
        scan_row_next   = scan_row_reg;
        frame_rows_next = frame_rows_reg;
        out_item_next   = '0;

        unique case (in_item_reg.req_type)
            bls_pkg::ReqBar:
            begin
                if (in_item_reg.row_index <= bls_pkg::LastRow)
                    frame_rows_next[bar_row] = bls_pkg::bar_code(in_item_reg.bar_height);
            end
            bls_pkg::ReqPixel:
            begin
                if (in_item_reg.row_index <= bls_pkg::LastRow)
                    frame_rows_next[in_item_reg.row_index] = 8'd1 << in_item_reg.pixel_column;
            end
            bls_pkg::ReqClear:
            begin
                for (int r = 0; r < bls_pkg::RowCount; r++)
                    frame_rows_next[r] = '0;
            end
            default:
            begin
                tick_count_next = step_fire ? '0 : tick_inc;
            end
        endcase

        priority if (scan_row_reg == 5'd0)
        begin
            out_item_next.source_byte  = frame_rows_reg[scan_row_reg];
            out_item_next.select_first = 1'b1;
            if (step_fire)
                scan_row_next = 5'd1;
        end
        else if (scan_row_reg == bls_pkg::LastRow)
        begin
            out_item_next.source_byte = frame_rows_reg[scan_row_reg];
            out_item_next.select_last = 1'b1;
            if (step_fire)
                scan_row_next = bls_pkg::BlankRow;
        end
        else if (scan_row_reg < bls_pkg::LastRow)
        begin
            out_item_next.source_byte = frame_rows_reg[scan_row_reg];
            out_item_next.sink_word   = 16'd1 << sink_shift[3:0];
            if (step_fire)
                scan_row_next = scan_row_reg + 5'd1;
        end
        else
        begin
            out_item_next.sink_word = bls_pkg::BlankSink;
            if (step_fire)
                scan_row_next = 5'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_period_reg <= 16'd1;
            tick_count_reg  <= '0;
            scan_row_reg    <= '0;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            for (int r = 0; r < bls_pkg::RowCount; r++)
                frame_rows_reg[r] <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                scan_period_reg <= cfg_wr_data;
            if (stage_fire)
            begin
                tick_count_reg <= tick_count_next;
                scan_row_reg   <= scan_row_next;
                frame_rows_reg <= frame_rows_next;
            end
            if (req.ready)
                in_valid_reg <= req.valid;
            if (res_load)
                out_valid_reg <= 1'b1;
            else if (scan.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg.req_type     <= req.req_type;
            in_item_reg.row_index    <= req.row_index;
            in_item_reg.bar_height   <= req.bar_height;
            in_item_reg.pixel_column <= req.pixel_column;
        end
        if (res_load)
            out_item_reg <= out_item_next;
    end

    assign scan.valid        = out_valid_reg;
    assign scan.source_byte  = out_item_reg.source_byte;
    assign scan.sink_word    = out_item_reg.sink_word;
    assign scan.select_first = out_item_reg.select_first;
    assign scan.select_last  = out_item_reg.select_last;

    `BLS_ASSERT_SAME(a_row_range, 1'b1, scan_row_reg <= bls_pkg::BlankRow)
    `BLS_ASSERT_SAME(a_selects_excl, out_valid_reg, !(scan.select_first && scan.select_last))
    `BLS_ASSERT_NEXT(a_tick_restart, res_load, tick_count_reg == '0)
    `BLS_ASSERT_SAME(a_blank_dark, out_valid_reg && (scan.sink_word == bls_pkg::BlankSink),
                     scan.source_byte == 8'd0)
    `BLS_ASSERT_NEXT(a_step_held, out_valid_reg && !scan.ready && !res_load, out_valid_reg)

endmodule
